// File: design/nlsi_pkg.sv
// Shared types, constants and beat layouts for the newline line-start indexer.
package nlsi_pkg;

	// Default sizing of the line-start table and of byte offsets.
	localparam int NLSI_TABLE_DEPTH = 4096;
	localparam int NLSI_OFFSET_BITS = 32;

	// Fixed field widths of the request and response beats.
	localparam int MODE_W        = 3;
	localparam int BYTE_W        = 8;
	localparam int FIELD_W       = 32;
	localparam int LINE_INDEX_W  = 12;
	localparam int KNOWN_LINES_W = 13;

	// The byte that ends a line.
	localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

	// Request operation codes; codes five to seven do nothing.
	typedef enum logic [MODE_W-1:0] {
		MODE_DATA    = 3'd0,
		MODE_LINE    = 3'd1,
		MODE_OFFSET  = 3'd2,
		MODE_END     = 3'd3,
		MODE_RESTART = 3'd4
	} nlsi_mode_t;

	// One request beat.
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [BYTE_W-1:0]  data_byte;
		logic [FIELD_W-1:0] line_number;
		logic [FIELD_W-1:0] query_offset;
	} nlsi_req_t;

	// One response beat.
	typedef struct packed {
		logic [FIELD_W-1:0]       line_start_value;
		logic [LINE_INDEX_W-1:0]  line_index_value;
		logic [KNOWN_LINES_W-1:0] known_lines;
		logic [FIELD_W-1:0]       scanned_offset;
		logic                     index_complete;
		logic                     offset_covered;
		logic                     table_full;
	} nlsi_rsp_t;

endpackage

// File: design/nlsi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module nlsi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/nlsi_query.sv
// Query sequencer: line-start lookup and binary search over the line-start table.
module nlsi_query
	import nlsi_pkg::*;
#(
	parameter int TABLE_DEPTH = NLSI_TABLE_DEPTH,
	parameter int OFFSET_BITS = NLSI_OFFSET_BITS,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
	localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   is_offset,
	input  logic [IDX_W-1:0]       line_idx,
	input  logic [OFFSET_BITS-1:0] target,
	input  logic [CNT_W-1:0]       entry_count,
	output logic [IDX_W-1:0]       raddr,
	input  logic [OFFSET_BITS-1:0] rdata,
	output logic                   done_q,
	output logic [OFFSET_BITS-1:0] start_val_q,
	output logic [CNT_W-1:0]       index_q
);

	typedef enum logic [2:0] {
		Q_IDLE,
		Q_LREAD,
		Q_LDATA,
		Q_ISSUE,
		Q_CMP
	} q_state_t;

	q_state_t               state_q;
	logic [CNT_W-1:0]       lo_q;
	logic [CNT_W-1:0]       hi_q;
	logic [CNT_W-1:0]       mid_q;
	logic [OFFSET_BITS-1:0] target_q;
	logic [CNT_W-1:0]       mid;
	logic [OFFSET_BITS-1:0] entry_val;

	// Midpoint of the open search window.
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Entry zero is always zero and is never written.
	assign entry_val = (mid_q == '0) ? '0 : rdata;

	// The read port follows the search midpoint, or the held line address.
	always_comb begin
		if (state_q == Q_ISSUE) begin
			raddr = mid[IDX_W-1:0];
		end else begin
			raddr = mid_q[IDX_W-1:0];
		end
	end

	// Sequencer state and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= Q_IDLE;
			done_q      <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			target_q    <= '0;
			start_val_q <= '0;
			index_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				Q_IDLE: begin
					if (start) begin
						lo_q     <= '0;
						hi_q     <= entry_count;
						target_q <= target;
						mid_q    <= CNT_W'(line_idx);
						state_q  <= is_offset ? Q_ISSUE : Q_LREAD;
					end
				end
				Q_LREAD: begin
					state_q <= Q_LDATA;
				end
				Q_LDATA: begin
					start_val_q <= entry_val;
					index_q     <= '0;
					done_q      <= 1'b1;
					state_q     <= Q_IDLE;
				end
				Q_ISSUE: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= Q_CMP;
					end else begin
						start_val_q <= '0;
						index_q     <= (lo_q == '0) ? '0 : lo_q - 1'b1;
						done_q      <= 1'b1;
						state_q     <= Q_IDLE;
					end
				end
				Q_CMP: begin
					if (entry_val <= target_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= Q_ISSUE;
				end
				default: begin
					state_q <= Q_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/newline_line_start_indexer.sv
// Top level of the newline line-start indexer: scan state, handshakes and table.
//
//  Port group   Direction  Handshake                  Beat
//  req          in         req_valid / req_ready      nlsi_req_t
//  rsp          out        rsp_valid / rsp_ready      nlsi_rsp_t
//  cfg          in         cfg_we, no wait            document size
//
// Data bytes, end-of-data, restart and unused codes each return one response, so
// bytes stream one per cycle while no query runs and the response register drains.
// A line-start query makes one table read through the registered read port.
// An offset query is a binary search over the known entries; each search step
// issues one read on the single table read port and compares.
// Reset needs no clearing pass: entry zero reads as zero without a write.
// req_ready drops while a query runs and while an unaccepted response waits.
module newline_line_start_indexer
	import nlsi_pkg::*;
#(
	parameter int TABLE_DEPTH = NLSI_TABLE_DEPTH,
	parameter int OFFSET_BITS = NLSI_OFFSET_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  nlsi_req_t          req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output nlsi_rsp_t          rsp,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CMP_W = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;
	localparam int LN_W  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic [OFFSET_BITS-1:0] size_q;
	logic [OFFSET_BITS-1:0] scan_q;
	logic [CNT_W-1:0]       count_q;
	logic                   done_q;
	logic                   over_q;
	logic                   busy_q;
	logic                   covered_q;
	logic                   rsp_valid_q;
	nlsi_rsp_t              rsp_q;

	logic [OFFSET_BITS-1:0] scan_n;
	logic [OFFSET_BITS-1:0] scan_inc;
	logic [CNT_W-1:0]       count_n;
	logic                   done_n;
	logic                   over_n;
	logic                   req_fire;
	logic                   is_query;
	logic                   tbl_we;
	logic [CNT_W-1:0]       last_line;
	logic [IDX_W-1:0]       line_idx;
	logic [OFFSET_BITS-1:0] target;
	logic                   covered;
	logic [IDX_W-1:0]       tbl_raddr;
	logic [OFFSET_BITS-1:0] tbl_rdata;
	logic                   q_done;
	logic [OFFSET_BITS-1:0] q_start_val;
	logic [CNT_W-1:0]       q_index;

	// Request acceptance: no query may run, and the response register must be free or draining.
	assign req_ready = !busy_q && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	assign is_query  = (req.mode == MODE_LINE) || (req.mode == MODE_OFFSET);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Query operands: clamp the line to the last entry, the offset to the size.
	assign last_line = count_q - 1'b1;
	assign line_idx  = (LN_W'(req.line_number) < LN_W'(last_line))
		? IDX_W'(req.line_number) : IDX_W'(last_line);
	assign target    = (CMP_W'(req.query_offset) < CMP_W'(size_q))
		? OFFSET_BITS'(req.query_offset) : size_q;
	assign covered   = (req.mode == MODE_OFFSET)
		&& (done_q || (CMP_W'(req.query_offset) < CMP_W'(scan_q)));

	// Scan state update for the accepted beat.
	always_comb begin
		count_n  = count_q;
		scan_n   = scan_q;
		done_n   = done_q;
		over_n   = over_q;
		tbl_we   = 1'b0;
		scan_inc = scan_q + OFFSET_BITS'(1);
		if (req_fire) begin
			unique case (req.mode)
				MODE_DATA: begin
					if (!done_q) begin
						if (scan_q >= size_q) begin
							done_n = 1'b1;
						end else begin
							if (req.data_byte == NEWLINE_CHAR) begin
								if (count_q < DEPTH_C) begin
									tbl_we  = 1'b1;
									count_n = count_q + 1'b1;
								end else begin
									over_n = 1'b1;
								end
							end
							scan_n = scan_inc;
							if (scan_inc >= size_q) begin
								done_n = 1'b1;
							end
						end
					end
				end
				MODE_END: begin
					done_n = 1'b1;
				end
				MODE_RESTART: begin
					count_n = CNT_W'(1);
					scan_n  = '0;
					over_n  = 1'b0;
					done_n  = (size_q == '0);
				end
				default: begin
				end
			endcase
		end
	end

	// Control state, configuration register and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			scan_q      <= '0;
			count_q     <= CNT_W'(1);
			done_q      <= 1'b1;
			over_q      <= 1'b0;
			busy_q      <= 1'b0;
			covered_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= OFFSET_BITS'(cfg_wdata);
			end
			scan_q  <= scan_n;
			count_q <= count_n;
			done_q  <= done_n;
			over_q  <= over_n;
			if (req_fire && is_query) begin
				busy_q    <= 1'b1;
				covered_q <= covered;
			end else if (q_done) begin
				busy_q <= 1'b0;
			end
			if ((req_fire && !is_query) || q_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response beat: state after the update, query fields from the sequencer.
	always_ff @(posedge clk) begin
		if (req_fire && !is_query) begin
			rsp_q.line_start_value <= '0;
			rsp_q.line_index_value <= '0;
			rsp_q.known_lines      <= KNOWN_LINES_W'(count_n);
			rsp_q.scanned_offset   <= FIELD_W'(scan_n);
			rsp_q.index_complete   <= done_n;
			rsp_q.offset_covered   <= 1'b0;
			rsp_q.table_full       <= over_n;
		end else if (q_done) begin
			rsp_q.line_start_value <= FIELD_W'(q_start_val);
			rsp_q.line_index_value <= LINE_INDEX_W'(q_index);
			rsp_q.known_lines      <= KNOWN_LINES_W'(count_q);
			rsp_q.scanned_offset   <= FIELD_W'(scan_q);
			rsp_q.index_complete   <= done_q;
			rsp_q.offset_covered   <= covered_q;
			rsp_q.table_full       <= over_q;
		end
	end

	// Line-start table.
	nlsi_ram #(
		.WIDTH(OFFSET_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(scan_inc),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	// Query sequencer.
	nlsi_query #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.OFFSET_BITS(OFFSET_BITS)
	) u_query (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (req_fire && is_query),
		.is_offset  (req.mode == MODE_OFFSET),
		.line_idx   (line_idx),
		.target     (target),
		.entry_count(count_q),
		.raddr      (tbl_raddr),
		.rdata      (tbl_rdata),
		.done_q     (q_done),
		.start_val_q(q_start_val),
		.index_q    (q_index)
	);

	// The entry count stays between one and the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(1)) && (count_q <= DEPTH_C))
		else $error("line-start entry count out of range");

	// The table is never written while a query reads it.
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_we && busy_q))
		else $error("table write during a query");

	// A query result only arrives while a query is outstanding.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_done |-> busy_q)
		else $error("query completion without an outstanding query");

	// The full flag only clears on a restart beat.
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(over_q && !(req_fire && (req.mode == MODE_RESTART))) |=> over_q)
		else $error("table full flag cleared without restart");

endmodule
